/* src/psc_pkg.sv */
// Package for the pressure sensor compensation block.
// Sequencer states, register indexes and datapath widths. No dependencies.
package psc_pkg;

  localparam int RawW   = 24;
  localparam int CoefW  = 16;
  localparam int MulW   = 26;
  localparam int ProdW  = 2 * MulW;
  localparam int TempW  = 20;
  localparam int WideW  = 40;
  localparam int AccW   = 66;
  localparam int OutTW  = 19;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SENS      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_TC = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TREF      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TSLOPE    = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DT, S_MT, S_TEMP, S_OFF, S_SENS, S_TI, S_DL, S_DV,
    S_DIFF, S_MLO, S_MHI, S_ACC, S_PQ, S_P2
  } seq_state_t;

endpackage

/* src/pressure_sensor_compensation.sv */
// Top level of the pressure sensor compensation block.
// Depends on psc_pkg and psc_mul.
//
// Takes one beat holding a raw pressure and a raw temperature conversion and
// returns one beat with the compensated temperature (0.01 degC) and pressure
// (0.1 mbar), first and second order, using six calibration words written on
// the cfg port (index 0..5; higher indexes are ignored). A value outside its
// valid range (temperature at or below -30.00 degC, pressure at or below
// 800.0 mbar) is not taken: the last good value is reported and its fresh
// flag is low. Pressure saturates at 16777215. All products go through one
// 26x26 signed multiplier driven by a sequencer, so the next input beat is
// taken only after the sequencer has loaded the output register and gone
// back to idle; s_tready is low meanwhile. The output register lets the
// next input beat be taken while a result still waits, and the sequencer
// holds in its last step only if the previous result has not been taken
// yet.
module pressure_sensor_compensation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [47:0]                  s_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [47:0]                  m_tdata,   // temperature_centi[18:0],
                                                  // pressure_deci_mbar[42:19], zero fill
  output logic [1:0]                   m_tuser,   // temperature_fresh[0], pressure_fresh[1]
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [psc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [psc_pkg::CoefW-1:0]    cfg_data
);
  import psc_pkg::*;

  seq_state_t state, state_next;

  // calibration words
  logic [CoefW-1:0] c1, c2, c3, c4, c5, c6;

  logic [RawW-1:0]           d1, d2;
  logic signed [RawW:0]      dt;
  logic signed [TempW-1:0]   temp;
  logic signed [WideW-1:0]   off, sens, offi, sensi, sdiff, odiff;
  logic [16:0]               ti;
  logic signed [TempW:0]     t2;
  logic signed [AccW-1:0]    acc;
  logic signed [46:0]        pq;

  logic signed [OutTW-1:0]   held_temperature;
  logic [RawW-1:0]           held_pressure;
  logic                      out_valid;
  logic                      tfresh, pfresh;

  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]   prod;

  logic                      load_out;

  psc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign load_out  = (state == S_P2) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0; c5 <= '0; c6 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS:      c1 <= cfg_data;
        REG_OFFSET:    c2 <= cfg_data;
        REG_SENS_TC:   c3 <= cfg_data;
        REG_OFFSET_TC: c4 <= cfg_data;
        REG_TREF:      c5 <= cfg_data;
        REG_TSLOPE:    c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- datapath helpers (truncating shifts toward zero) ----
  logic signed [ProdW-1:0] rnd23, rnd7, rnd8;
  logic signed [TempW-1:0] temp_calc, dlow, dvlow;
  logic [50:0]             dt3;
  logic [39:0]             dsq;
  logic [41:0]             dsq3, dsq5;
  logic signed [AccW-1:0]  rnd21, prod_wide;
  logic signed [46:0]      pq_calc, rnd13;
  logic signed [33:0]      p2;
  logic                    temp_low, temp_vlow;

  always_comb begin
    rnd23     = prod + (prod[ProdW-1] ? 52'sd8388607 : 52'sd0);
    rnd7      = prod + (prod[ProdW-1] ? 52'sd127 : 52'sd0);
    rnd8      = prod + (prod[ProdW-1] ? 52'sd255 : 52'sd0);
    temp_calc = 20'sd2000 + TempW'(rnd23 >>> 23);
    dlow      = temp - 20'sd2000;
    dvlow     = temp + 20'sd1500;
    temp_low  = temp < 20'sd2000;
    temp_vlow = temp < -20'sd1500;
    dt3       = {1'b0, prod[49:0]} + {prod[49:0], 1'b0};
    dsq       = prod[39:0];
    dsq3      = {2'b0, dsq} + {1'b0, dsq, 1'b0};
    dsq5      = {2'b0, dsq} + {dsq, 2'b0};
    prod_wide = AccW'(prod);
    rnd21     = acc + (acc[AccW-1] ? 66'sd2097151 : 66'sd0);
    pq_calc   = 47'(rnd21 >>> 21) - 47'(odiff);
    rnd13     = pq + (pq[46] ? 47'sd8191 : 47'sd0);
    p2        = 34'(rnd13 >>> 13);
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_DT;
      S_DT:   state_next = S_MT;
      S_MT: begin
        mul_a = MulW'(dt);
        mul_b = $signed({10'd0, c6});
        state_next = S_TEMP;
      end
      S_TEMP: begin
        mul_a = $signed({10'd0, c4});
        mul_b = MulW'(dt);
        state_next = S_OFF;
      end
      S_OFF: begin
        mul_a = $signed({10'd0, c3});
        mul_b = MulW'(dt);
        state_next = S_SENS;
      end
      S_SENS: begin
        mul_a = MulW'(dt);
        mul_b = MulW'(dt);
        state_next = S_TI;
      end
      S_TI: begin
        mul_a = MulW'(dlow);
        mul_b = MulW'(dlow);
        state_next = S_DL;
      end
      S_DL: begin
        mul_a = MulW'(dvlow);
        mul_b = MulW'(dvlow);
        state_next = S_DV;
      end
      S_DV:   state_next = S_DIFF;
      S_DIFF: state_next = S_MLO;
      S_MLO: begin
        mul_a = $signed({2'd0, d1});
        mul_b = $signed({6'd0, sdiff[19:0]});
        state_next = S_MHI;
      end
      S_MHI: begin
        mul_a = $signed({2'd0, d1});
        mul_b = MulW'($signed(sdiff[39:20]));
        state_next = S_ACC;
      end
      S_ACC:  state_next = S_PQ;
      S_PQ:   state_next = S_P2;
      S_P2:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_tvalid) begin
        d1 <= s_tdata[23:0];
        d2 <= s_tdata[47:24];
      end
      S_DT:   dt <= $signed({1'b0, d2}) - $signed({1'b0, c5, 8'd0});
      S_TEMP: temp <= temp_calc;
      S_OFF:  off <= $signed({8'd0, c2, 16'd0}) + WideW'(rnd7 >>> 7);
      S_SENS: sens <= $signed({9'd0, c1, 15'd0}) + WideW'(rnd8 >>> 8);
      S_TI:   ti <= temp_low ? dt3[49:33] : {5'd0, prod[47:36]};
      S_DL: begin
        if (temp_low) begin
          offi  <= $signed(dsq3[40:1]);
          sensi <= $signed({1'b0, dsq5[41:3]});
        end else begin
          offi  <= $signed({4'd0, dsq[39:4]});
          sensi <= '0;
        end
      end
      S_DV: begin
        if (temp_vlow) begin
          offi  <= offi + $signed({dsq[36:0], 3'd0}) - $signed(dsq);
          sensi <= sensi + $signed({dsq[37:0], 2'd0});
        end
        t2 <= (TempW+1)'(temp) - $signed({4'd0, ti});
      end
      S_DIFF: begin
        sdiff <= sens - sensi;
        odiff <= off - offi;
      end
      // low partial product lands here, high partial in the next cycle
      S_MHI:  acc <= prod_wide;
      S_ACC:  acc <= acc + (prod_wide <<< 20);
      S_PQ:   pq <= pq_calc;
      S_P2:   ;
      default: ;
    endcase
  end

  // ---- held values and output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_pressure    <= '0;
      out_valid        <= 1'b0;
      tfresh           <= 1'b0;
      pfresh           <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        tfresh    <= t2 > -21'sd3000;
        pfresh    <= p2 > 34'sd8000;
        if (t2 > -21'sd3000) held_temperature <= OutTW'(t2);
        if (p2 > 34'sd8000)
          held_pressure <= (p2 > 34'sd16777215) ? 24'hFFFFFF : p2[23:0];
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, held_pressure, held_temperature};
  assign m_tuser  = {pfresh, tfresh};

  // ---- checks ----
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DT))
    else $error("accepted beat did not start the sequencer");

  a_temp_fresh_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (held_temperature > -19'sd3000))
    else $error("fresh temperature at or below floor");

  a_press_fresh_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (held_pressure > 24'd8000))
    else $error("fresh pressure at or below floor");

  a_hold_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_P2 && out_valid && !m_tready) |=> (state == S_P2))
    else $error("result overwrote an untaken beat");

endmodule

/* src/psc_mul.sv */
// Shared signed multiplier with registered product.
// Depends on psc_pkg.
module psc_mul (
  input  logic                               clk,
  input  logic signed [psc_pkg::MulW-1:0]    a,
  input  logic signed [psc_pkg::MulW-1:0]    b,
  output logic signed [psc_pkg::ProdW-1:0]   prod
);
  import psc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
